// ----- sv/rcsf_pkg.sv -----
// shared types and constants for the riff chunk size fixer
package rcsf_pkg;

  localparam int unsigned PosW = 32;

  localparam logic [31:0] TagRiff = 32'h52494646;
  localparam logic [31:0] TagWave = 32'h57415645;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    PhTag,
    PhLen,
    PhSkip,
    PhPass
  } phase_e;

  // one queued job: a single byte, or a whole length field of four bytes
  typedef struct packed {
    logic [31:0] data;
    logic        quad;
    logic        rew;
    logic        err;
    logic        fix;
    logic        last;
  } job_t;

endpackage

// ----- sv/riff_chunk_size_fixer_unit.sv -----
// top level of the riff chunk size fixer
//
//  channel   dir  handshake                       payload
//  cfg       in   cfg_valid_i / cfg_ready_o       cfg_data_i = total_length
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata = data_byte
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata = out_byte, tuser = flags, tlast
//
// one input item per cycle while s_axis_tready is high and one result item per
// cycle while m_axis_tready is high; a length field takes four input items and
// yields four result items after its fourth byte. a four-job queue lets the input
// side run on while the output side is stalled, tready drops when it fills.
// reset or a configuration write returns the parser to the start of a file.
module riff_chunk_size_fixer_unit import rcsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,     // total_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]  m_axis_tuser,   // [0] byte_rewritten, [1] header_truncated, [2] any_fixed
  output logic        m_axis_tlast
);

  logic push;
  job_t push_job;
  logic q_full;
  logic q_valid;
  logic pop;
  job_t q_job;

  assign cfg_ready_o = 1'b1;

  rcsf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  rcsf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .job_o   (q_job)
  );

  rcsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (q_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- sv/rcsf_front.sv -----
// front part: takes file bytes, tracks tags and lengths, emits jobs
module rcsf_front import rcsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_data_i,
  input  logic        q_full_i,
  output logic        push_o,
  output job_t        job_o
);

  logic [PosW-1:0] rem_q, rem_d;
  logic [PosW-1:0] rem_m1_q, rem_m1_d;
  logic [PosW-1:0] skip_q, skip_d;
  phase_e          phase_q, phase_d;
  logic [1:0]      fidx_q, fidx_d;
  logic [31:0]     tag_q, tag_d;
  logic [31:0]     hold_q, hold_d;
  logic            fix_q, fix_d;
  logic            err_q, err_d;

  logic        accept;
  logic        past_end;
  logic        trunc;
  phase_e      eff_phase;
  logic [31:0] len_new;
  logic [31:0] rem_after;
  logic [31:0] len_out;
  logic [31:0] tag_new;
  logic        is_riff;
  logic        rewr;
  logic        quad;

  assign accept     = in_valid_i && !q_full_i;
  assign in_ready_o = !q_full_i;

  assign past_end  = (rem_q == '0);
  assign trunc     = ((phase_q == PhTag) || (phase_q == PhLen)) && (fidx_q == 2'd0) &&
                     (rem_q < PosW'(4));
  assign eff_phase = trunc ? PhPass : phase_q;
  assign len_new   = {in_data_i, hold_q[31:8]};
  assign tag_new   = {tag_q[23:0], in_data_i};
  assign rem_after = 32'(rem_m1_q);
  assign is_riff   = (tag_q == TagRiff);
  assign rewr      = is_riff ? (len_new != rem_after) : (len_new > rem_after);
  assign len_out   = rewr ? rem_after : len_new;
  assign quad      = !past_end && (eff_phase == PhLen) && (fidx_q == 2'd3);

  // next state
  always_comb begin
    rem_d    = rem_q;
    rem_m1_d = rem_m1_q;
    skip_d   = skip_q;
    phase_d  = phase_q;
    fidx_d   = fidx_q;
    tag_d    = tag_q;
    hold_d   = hold_q;
    fix_d    = fix_q;
    err_d    = err_q;
    if (accept && !past_end) begin
      rem_d    = rem_q - PosW'(1);
      rem_m1_d = rem_m1_q - PosW'(1);
      if (trunc) begin
        err_d   = 1'b1;
        phase_d = PhPass;
      end
      case (eff_phase)
        PhTag: begin
          tag_d  = tag_new;
          fidx_d = fidx_q + 2'd1;
          if (fidx_q == 2'd3) begin
            phase_d = (tag_new == TagWave) ? PhTag : PhLen;
          end
        end
        PhLen: begin
          hold_d = len_new;
          fidx_d = fidx_q + 2'd1;
          if (fidx_q == 2'd3) begin
            if (rewr) begin
              fix_d = 1'b1;
            end
            if (is_riff) begin
              phase_d = PhTag;
            end else begin
              skip_d  = len_out[PosW-1:0];
              phase_d = (len_out != '0) ? PhSkip : PhTag;
            end
          end
        end
        PhSkip: begin
          skip_d = skip_q - PosW'(1);
          if (skip_q == PosW'(1)) begin
            phase_d = PhTag;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // job toward the queue; nothing on the first three bytes of a length field
  always_comb begin
    push_o        = accept && (past_end || (eff_phase != PhLen) || (fidx_q == 2'd3));
    job_o.quad    = quad;
    job_o.data    = quad ? len_out : {24'd0, in_data_i};
    job_o.rew     = quad && rewr;
    job_o.err     = err_d;
    job_o.fix     = fix_d;
    job_o.last    = !past_end && (rem_m1_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q    <= '0;
      rem_m1_q <= '1;
      skip_q   <= '0;
      phase_q  <= PhTag;
      fidx_q   <= 2'd0;
      tag_q    <= '0;
      hold_q   <= '0;
      fix_q    <= 1'b0;
      err_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      // new file: everything back to its start
      rem_q    <= cfg_data_i[PosW-1:0];
      rem_m1_q <= cfg_data_i[PosW-1:0] - PosW'(1);
      skip_q   <= '0;
      phase_q  <= PhTag;
      fidx_q   <= 2'd0;
      tag_q    <= '0;
      hold_q   <= '0;
      fix_q    <= 1'b0;
      err_q    <= 1'b0;
    end else begin
      rem_q    <= rem_d;
      rem_m1_q <= rem_m1_d;
      skip_q   <= skip_d;
      phase_q  <= phase_d;
      fidx_q   <= fidx_d;
      tag_q    <= tag_d;
      hold_q   <= hold_d;
      fix_q    <= fix_d;
      err_q    <= err_d;
    end
  end

endmodule

// ----- sv/rcsf_queue.sv -----
// short job queue between the front and back parts
module rcsf_queue import rcsf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output job_t job_o
);

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

endmodule

// ----- sv/rcsf_back.sv -----
// back part: plays jobs out as result items, four beats for a length field
module rcsf_back import rcsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  job_t       q_job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_data_o,
  output logic [2:0] out_user_o,
  output logic       out_last_o
);

  logic       valid_q;
  job_t       job_q;
  logic [1:0] beat_q;
  logic       last_beat;
  logic       done;

  assign last_beat = !job_q.quad || (beat_q == 2'd3);
  assign done      = !valid_q || (out_ready_i && last_beat);
  assign pop_o     = done && q_valid_i;

  always_comb begin
    case (beat_q)
      2'd0:    out_data_o = job_q.data[7:0];
      2'd1:    out_data_o = job_q.data[15:8];
      2'd2:    out_data_o = job_q.data[23:16];
      2'd3:    out_data_o = job_q.data[31:24];
      default: out_data_o = job_q.data[7:0];
    endcase
  end

  assign out_valid_o = valid_q;
  assign out_user_o  = {job_q.fix, job_q.err, job_q.rew};
  assign out_last_o  = job_q.last && last_beat;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= q_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= 2'd0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      beat_q  <= 2'd0;
    end else if (done) begin
      valid_q <= 1'b0;
    end else if (out_ready_i) begin
      beat_q <= beat_q + 2'd1;
    end
  end

endmodule

// ----- sv/rcsf_checker.sv -----
// port-level checks for the riff chunk size fixer, bound to the top level
module rcsf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a rewritten length byte always carries the sticky fixed flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2])
    else $error("rewritten byte without any_fixed");

  // nothing leaves the block on the cycle after reset
  assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind riff_chunk_size_fixer_unit rcsf_checker u_rcsf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
